### hdl/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_pkg: shared types, constants and mixing functions
// Holds the start value, the queue entry type and the round functions that
// the front and back parts of the streaming hash use.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam logic [31:0] HashStart = 32'd5381;
  localparam int unsigned QueueDepthDef = 2;

  // One finished key on its way from the front part to the back part.
  typedef struct packed {
    logic [31:0] hash;
    logic        seen;
  } fin_t;

  // Sign-extend one byte to 32 bits.
  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // Mixing round for a full 32-bit word.
  function automatic logic [31:0] word_round(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] h1;
    logic [31:0] t;
    logic [31:0] h2;
    h1 = h + {16'd0, w[15:0]};
    t  = {5'd0, w[31:16], 11'd0} ^ h1;
    h2 = {h1[15:0], 16'd0} ^ t;
    return h2 + {11'd0, h2[31:11]};
  endfunction

  // Mixing round for a tail of one to three bytes; other counts pass h through.
  function automatic logic [31:0] tail_round(input logic [31:0] h, input logic [31:0] w,
                                             input logic [1:0] n);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    a = h;
    b = h;
    s = sext8(w[23:16]);
    case (n)
      2'd3: begin
        a = h + {16'd0, w[15:0]};
        b = a ^ {a[15:0], 16'd0};
        b = b ^ {s[13:0], 18'd0};
        b = b + {11'd0, b[31:11]};
      end
      2'd2: begin
        a = h + {16'd0, w[15:0]};
        b = a ^ {a[20:0], 11'd0};
        b = b + {17'd0, b[31:17]};
      end
      2'd1: begin
        a = h + sext8(w[7:0]);
        b = a ^ {a[21:0], 10'd0};
        b = b + {1'b0, b[31:1]};
      end
      default: begin
        b = h;
      end
    endcase
    return b;
  endfunction

  // First three steps of the final avalanche.
  function automatic logic [31:0] avalanche_a(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ {h[28:0], 3'd0};
    x = x + {5'd0, x[31:5]};
    x = x ^ {x[27:0], 4'd0};
    return x;
  endfunction

  // Last three steps of the final avalanche.
  function automatic logic [31:0] avalanche_b(input logic [31:0] h);
    logic [31:0] x;
    x = h + {17'd0, h[31:17]};
    x = x ^ {x[6:0], 25'd0};
    x = x + {6'd0, x[31:6]};
    return x;
  endfunction

endpackage
`default_nettype wire

### hdl/shs_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_stream_if: valid/ready channels of the streaming hash
// The key word channel and the digest channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface shs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface
`default_nettype wire

### hdl/shs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_front: word intake and running hash
// Accepts key words, runs the word or tail round on the running hash and
// pushes each finished key into the queue.
// ----------------------------------------------------------------------------
module shs_front
  import shs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_word_i,
  output logic             push_o,
  output fin_t             push_data_o,
  input  wire logic        full_i
);

  logic [31:0] hash_q, hash_d;
  logic        seen_q, seen_d;
  logic        accept;
  logic [31:0] word_h;
  logic [31:0] tail_h;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Both candidate rounds from the running hash.
  assign word_h = word_round(hash_q, data_word_i);
  assign tail_h = tail_round(hash_q, data_word_i, byte_count_i[1:0]);

  // Classify the item: inner word, full last word, short tail or empty tail.
  always_comb begin
    hash_d      = hash_q;
    seen_d      = seen_q;
    push_o      = 1'b0;
    push_data_o = '{hash: hash_q, seen: seen_q};
    if (accept) begin
      if (!last_word_i) begin
        hash_d = word_h;
        seen_d = 1'b1;
      end else begin
        push_o = 1'b1;
        if (byte_count_i[2]) begin
          push_data_o = '{hash: word_h, seen: 1'b1};
        end else if (byte_count_i[1:0] != 2'd0) begin
          push_data_o = '{hash: tail_h, seen: 1'b1};
        end
        hash_d = HashStart;
        seen_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashStart;
      seen_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      seen_q <= seen_d;
    end
  end

endmodule
`default_nettype wire

### hdl/shs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_queue: finished-key queue
// A small first-in first-out buffer that decouples the front and back parts.
// ----------------------------------------------------------------------------
module shs_queue
  import shs_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire fin_t push_data_i,
  output logic      full_o,
  output logic      pop_valid_o,
  output fin_t      pop_data_o,
  input  wire logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  fin_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o      = (cnt_q == FullCnt);
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage is payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### hdl/shs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shs_back: avalanche pipeline and digest register
// Runs the six-step avalanche over two stages and holds the digest until it
// is taken.
// ----------------------------------------------------------------------------
module shs_back
  import shs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire fin_t        q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hash_value_o
);

  logic        s1_vld_q;
  fin_t        s1_q;
  logic        out_vld_q;
  logic [31:0] out_q;
  logic        adv_out;
  logic        adv_s1;

  // A stage moves when the next one is empty or moving.
  assign adv_out = !out_vld_q || out_ready_i;
  assign adv_s1  = !s1_vld_q || adv_out;
  assign q_pop_o = q_valid_i && adv_s1;

  assign out_valid_o  = out_vld_q;
  assign hash_value_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_vld_q <= q_valid_i;
      end
      if (adv_out) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // Payload stages; an empty key gives a zero digest.
  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      s1_q <= '{hash: avalanche_a(q_data_i.hash), seen: q_data_i.seen};
    end
    if (adv_out) begin
      out_q <= s1_q.seen ? avalanche_b(s1_q.hash) : 32'd0;
    end
  end

endmodule
`default_nettype wire

### hdl/superfast_hash_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// superfast_hash_stream: streaming 32-bit SuperFastHash-style digest
// Takes a key as little-endian words and returns one digest per key.
// ----------------------------------------------------------------------------
//  Channel | Dir | Fields                                  | Item
//  in_i    | in  | data_word[31:0] byte_count[2:0] last_wd | one key word
//  out_o   | out | hash_value[31:0]                        | one key digest
//
// One word is accepted per cycle while the queue is not full; the word round
// runs in the cycle of acceptance on the running hash register.
// The edge that accepts the last word of a key writes its queue entry; the
// digest then passes through the avalanche stage and the output register,
// each of which holds while the stage after it is stalled.
// Reset puts the running hash at its start value and empties all stages.
// A stalled output fills the two-stage pipeline and then the queue before
// ready drops on the input.
// ----------------------------------------------------------------------------
module superfast_hash_stream
  import shs_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  shs_in_if.sink    in_i,
  shs_out_if.source out_o
);

  logic push;
  fin_t push_data;
  logic full;
  logic q_valid;
  fin_t q_data;
  logic q_pop;

  shs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_word_i  (in_i.data_word),
    .byte_count_i (in_i.byte_count),
    .last_word_i  (in_i.last_word),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  shs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_data),
    .pop_i       (q_pop)
  );

  shs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .hash_value_o (out_o.hash_value)
  );

endmodule
`default_nettype wire
